[hw/rtl/uapq_pkg.sv]
// shared types for the unsorted array priority queue
`default_nettype none

package uapq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_LARGER    = 3'd3,
    STATUS_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIND   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_RESCAN = 4'b1000
  } state_e;

  localparam int KeyW  = 32;
  localparam int PrioW = 32;

endpackage

`default_nettype wire

[hw/rtl/unsorted_array_priority_queue.sv]
// top level: priority queue kept as an unsorted array in arrival order
// done_o: enqueue, clear, and dequeue or change on an empty queue strobe it in the cycle after start_i
//   change priority: key search, one ram read per cycle, then the strobe
//   dequeue: shift the entries behind the removed one, none when the last entry goes, then a
//   rescan of the remaining entries for the new head, then the strobe
// throughput: one item at a time, busy_o drops as done_o rises; the single ram read port sets it
// reset: entry count cleared, sequencer idle; head cache and ram contents are not cleared,
//   results come out as a one-cycle done_o strobe, the receiver cannot stall
`default_nettype none

module unsorted_array_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] item_key_i,
  input  wire logic signed [31:0] item_priority_i,
  output      logic        done_o,
  output      logic [31:0] removed_key_o,
  output      logic [2:0]  status_o,
  output      logic [6:0]  entry_total_o,
  output      logic        head_valid_o,
  output      logic [31:0] head_key_o,
  output      logic signed [31:0] head_priority_o
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int WordW = uapq_pkg::KeyW + uapq_pkg::PrioW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // sequencer and queue state
  uapq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;     // next ram address to read
  logic             rd_vld_q, rd_vld_d;     // read data arrives this cycle
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;     // address of arriving read data
  logic             done_q, done_d;

  // latched item for the key search
  logic [31:0]        key_q, key_d;
  logic signed [31:0] prio_q, prio_d;

  // cached most urgent entry
  logic [AddrW-1:0]   head_idx_q, head_idx_d;
  logic [31:0]        head_key_q, head_key_d;
  logic signed [31:0] head_prio_q, head_prio_d;

  // result registers
  logic [31:0]        removed_key_q, removed_key_d;
  uapq_pkg::status_e  status_q, status_d;

  // ram port
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [WordW-1:0]   ram_wdata;
  logic [WordW-1:0]   ram_rdata;
  logic [31:0]        rd_key;
  logic signed [31:0] rd_prio;

  assign rd_key  = ram_rdata[WordW-1 -: 32];
  assign rd_prio = signed'(ram_rdata[31:0]);

  // entries stored as {key, priority}
  uapq_ram #(
    .Width (WordW),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rd_ptr_d      = rd_ptr_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    done_d        = 1'b0;
    key_d         = key_q;
    prio_d        = prio_q;
    head_idx_d    = head_idx_q;
    head_key_d    = head_key_q;
    head_prio_d   = head_prio_q;
    removed_key_d = removed_key_q;
    status_d      = status_q;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_q;
    ram_wdata     = {key_q, prio_q};

    case (state_q)
      uapq_pkg::ST_IDLE: begin
        if (start_i) begin
          status_d      = uapq_pkg::STATUS_OK;
          removed_key_d = '0;
          case (uapq_pkg::op_e'(op_i))
            uapq_pkg::OP_ENQUEUE: begin
              done_d = 1'b1;
              if (cnt_q == CapCnt) begin
                status_d = uapq_pkg::STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AddrW-1:0];
                ram_wdata = {item_key_i, item_priority_i};
                cnt_d     = cnt_q + CntOne;
                // newest entry wins only on a strictly smaller number
                if (cnt_q == '0 || item_priority_i < head_prio_q) begin
                  head_idx_d  = cnt_q[AddrW-1:0];
                  head_key_d  = item_key_i;
                  head_prio_d = item_priority_i;
                end
              end
            end
            uapq_pkg::OP_DEQUEUE: begin
              if (cnt_q == '0) begin
                status_d = uapq_pkg::STATUS_EMPTY;
                done_d   = 1'b1;
              end else begin
                removed_key_d = head_key_q;
                cnt_d         = cnt_q - CntOne;
                if (CntW'(head_idx_q) == cnt_q - CntOne) begin
                  // removed the last entry, nothing to shift
                  if (cnt_q == CntOne) begin
                    done_d = 1'b1;
                  end else begin
                    state_d  = uapq_pkg::ST_RESCAN;
                    rd_ptr_d = '0;
                  end
                end else begin
                  state_d  = uapq_pkg::ST_SHIFT;
                  rd_ptr_d = CntW'(head_idx_q) + CntOne;
                end
              end
            end
            uapq_pkg::OP_CHANGE: begin
              if (cnt_q == '0) begin
                status_d = uapq_pkg::STATUS_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                key_d    = item_key_i;
                prio_d   = item_priority_i;
                rd_ptr_d = '0;
                state_d  = uapq_pkg::ST_FIND;
              end
            end
            uapq_pkg::OP_CLEAR: begin
              cnt_d  = '0;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // linear search for the first entry holding the key
      uapq_pkg::ST_FIND: begin
        if (rd_vld_q && rd_key == key_q) begin
          done_d  = 1'b1;
          state_d = uapq_pkg::ST_IDLE;
          if (rd_prio < prio_q) begin
            status_d = uapq_pkg::STATUS_LARGER;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_q;
            ram_wdata = {key_q, prio_q};
            // a lowered number can only improve this entry's rank
            if (rd_idx_q == head_idx_q || prio_q < head_prio_q ||
                (prio_q == head_prio_q && rd_idx_q < head_idx_q)) begin
              head_idx_d  = rd_idx_q;
              head_key_d  = key_q;
              head_prio_d = prio_q;
            end
          end
        end else if (rd_ptr_q == cnt_q) begin
          status_d = uapq_pkg::STATUS_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = uapq_pkg::ST_IDLE;
        end else begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_ptr_q[AddrW-1:0];
          rd_ptr_d = rd_ptr_q + CntOne;
        end
      end

      // close the gap: read entry i+1, write it to i the next cycle
      uapq_pkg::ST_SHIFT: begin
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (rd_ptr_q <= cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_ptr_q[AddrW-1:0];
          rd_ptr_d = rd_ptr_q + CntOne;
        end else begin
          state_d  = uapq_pkg::ST_RESCAN;
          rd_ptr_d = '0;
        end
      end

      // full scan for the new head, first minimum wins
      uapq_pkg::ST_RESCAN: begin
        if (rd_vld_q && (rd_idx_q == '0 || rd_prio < head_prio_q)) begin
          head_idx_d  = rd_idx_q;
          head_key_d  = rd_key;
          head_prio_d = rd_prio;
        end
        if (rd_ptr_q == cnt_q) begin
          done_d  = 1'b1;
          state_d = uapq_pkg::ST_IDLE;
        end else begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_ptr_q[AddrW-1:0];
          rd_ptr_d = rd_ptr_q + CntOne;
        end
      end

      default: begin
        state_d = uapq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= uapq_pkg::ST_IDLE;
      cnt_q    <= '0;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    key_q         <= key_d;
    prio_q        <= prio_d;
    head_idx_q    <= head_idx_d;
    head_key_q    <= head_key_d;
    head_prio_q   <= head_prio_d;
    removed_key_q <= removed_key_d;
    status_q      <= status_d;
  end

  // count and head cache are settled whenever done_o is high
  assign busy_o          = (state_q != uapq_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign removed_key_o   = removed_key_q;
  assign status_o        = status_q;
  assign entry_total_o   = 7'(cnt_q);
  assign head_valid_o    = (cnt_q != '0);
  assign head_key_o      = head_valid_o ? head_key_q : '0;
  assign head_priority_o = head_valid_o ? head_prio_q : '0;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("entry count above capacity");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == uapq_pkg::OP_CLEAR) |=> (done_o && cnt_q == '0))
    else $error("clear did not empty the queue");

  a_enqueue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == uapq_pkg::OP_ENQUEUE && cnt_q != CapCnt)
    |=> (done_o && cnt_q == $past(cnt_q) + CntOne))
    else $error("enqueue did not grow the count");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == uapq_pkg::STATUS_FULL) |-> cnt_q == CapCnt)
    else $error("full reported below capacity");

endmodule

`default_nettype wire

[hw/rtl/uapq_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module uapq_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
